### hdl/assert_macros.svh
// assertion macros included by the parser rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is low
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same check with a caller-supplied message
`define ASSERT_CLKD_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### hdl/mdp_pkg.sv
// types, codes and decode function for the method descriptor parser
package mdp_pkg;

  // one input request: a descriptor character
  typedef struct packed {
    logic       start_req;
    logic [7:0] ch;
  } in_req_t;

  // one result
  typedef struct packed {
    logic [1:0] error_kind;
    logic [7:0] arg_count;
    logic [3:0] ret_type;
    logic       ret_array;
  } out_rsp_t;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE      = 7'b000_0001,
    PH_ARGS      = 7'b000_0010,
    PH_ARGS_ARR  = 7'b000_0100,
    PH_ARG_CLASS = 7'b000_1000,
    PH_RET       = 7'b001_0000,
    PH_RET_CLASS = 7'b010_0000,
    PH_DONE      = 7'b100_0000
  } phase_e;

  // error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_BAD_LETTER = 2'd1;
  localparam logic [1:0] ERR_NOT_METHOD = 2'd2;

  // type codes
  localparam logic [3:0] TY_BYTE    = 4'd0;
  localparam logic [3:0] TY_CHAR    = 4'd1;
  localparam logic [3:0] TY_DOUBLE  = 4'd2;
  localparam logic [3:0] TY_FLOAT   = 4'd3;
  localparam logic [3:0] TY_INT     = 4'd4;
  localparam logic [3:0] TY_LONG    = 4'd5;
  localparam logic [3:0] TY_SHORT   = 4'd6;
  localparam logic [3:0] TY_BOOLEAN = 4'd7;
  localparam logic [3:0] TY_VOID    = 4'd8;
  localparam logic [3:0] TY_REF     = 4'd9;
  localparam logic [3:0] TY_NONE    = 4'd15;

  // descriptor characters
  localparam logic [7:0] CH_OPEN  = 8'h28; // (
  localparam logic [7:0] CH_CLOSE = 8'h29; // )
  localparam logic [7:0] CH_SEMI  = 8'h3B; // ;
  localparam logic [7:0] CH_CLASS = 8'h4C; // L
  localparam logic [7:0] CH_ARRAY = 8'h5B; // [

  localparam logic [7:0] CNT_MAX = 8'hFF;

  // primitive letter to type code
  function automatic logic [3:0] letter_type(input logic [7:0] c);
    logic [3:0] t;
    unique case (c)
      8'h42:   t = TY_BYTE;    // B
      8'h43:   t = TY_CHAR;    // C
      8'h44:   t = TY_DOUBLE;  // D
      8'h46:   t = TY_FLOAT;   // F
      8'h49:   t = TY_INT;     // I
      8'h4A:   t = TY_LONG;    // J
      8'h53:   t = TY_SHORT;   // S
      8'h5A:   t = TY_BOOLEAN; // Z
      8'h56:   t = TY_VOID;    // V
      default: t = TY_NONE;
    endcase
    return t;
  endfunction

endpackage

### hdl/method_descriptor_parser.sv
// method descriptor parser top level
//
// Takes one descriptor character per request and gives one result when the
// return type completes or an error is found. A request is registered at
// acceptance into the input register and decoded from there into the result
// register when it can take a new value. One character is accepted every
// cycle; the input stalls only while the input register holds a
// character and the result register is full and stalled.
// Characters after a result are ignored until the next start request.
module method_descriptor_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mdp_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mdp_pkg::out_rsp_t out_rsp_o
);
  import mdp_pkg::*;

`include "assert_macros.svh"

  logic     in_valid_q;
  in_req_t  in_req_q;
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, out_rsp_d;
  phase_e   phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d, cnt_inc;
  logic     arr_q, arr_d;
  logic     out_free, proc, emit;
  logic [3:0] ty;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
  end

  // decode of the registered character
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 8'd1;
  assign ty      = letter_type(in_req_q.ch);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    arr_d     = arr_q;
    emit      = 1'b0;
    out_rsp_d = '{error_kind: ERR_OK, arg_count: cnt_q, ret_type: TY_BYTE,
                  ret_array: 1'b0};
    if (proc) begin
      if (in_req_q.start_req) begin
        cnt_d = '0;
        arr_d = 1'b0;
        if (in_req_q.ch != CH_OPEN) begin
          emit                 = 1'b1;
          out_rsp_d.error_kind = ERR_NOT_METHOD;
          out_rsp_d.arg_count  = '0;
          phase_d              = PH_DONE;
        end else begin
          phase_d = PH_ARGS;
        end
      end else begin
        unique case (phase_q)
          PH_ARGS, PH_ARGS_ARR: begin
            if (in_req_q.ch == CH_CLOSE && phase_q == PH_ARGS) begin
              phase_d = PH_RET;
            end else if (in_req_q.ch == CH_ARRAY) begin
              phase_d = PH_ARGS_ARR;
            end else if (in_req_q.ch == CH_CLASS) begin
              phase_d = PH_ARG_CLASS;
            end else if (ty == TY_NONE || ty == TY_VOID) begin
              emit                 = 1'b1;
              out_rsp_d.error_kind = ERR_BAD_LETTER;
              phase_d              = PH_DONE;
            end else begin
              cnt_d   = cnt_inc;
              phase_d = PH_ARGS;
            end
          end
          PH_ARG_CLASS: begin
            if (in_req_q.ch == CH_SEMI) begin
              cnt_d   = cnt_inc;
              phase_d = PH_ARGS;
            end
          end
          PH_RET: begin
            if (in_req_q.ch == CH_ARRAY) begin
              arr_d = 1'b1;
            end else if (in_req_q.ch == CH_CLASS) begin
              phase_d = PH_RET_CLASS;
            end else if (ty == TY_NONE || (ty == TY_VOID && arr_q)) begin
              emit                 = 1'b1;
              out_rsp_d.error_kind = ERR_BAD_LETTER;
              phase_d              = PH_DONE;
            end else begin
              emit                = 1'b1;
              out_rsp_d.ret_type  = ty;
              out_rsp_d.ret_array = arr_q;
              phase_d             = PH_DONE;
            end
          end
          PH_RET_CLASS: begin
            if (in_req_q.ch == CH_SEMI) begin
              emit                = 1'b1;
              out_rsp_d.ret_type  = TY_REF;
              out_rsp_d.ret_array = arr_q;
              phase_d             = PH_DONE;
            end
          end
          default: begin
            // idle or done: character ignored
          end
        endcase
      end
    end
  end

  // result register valid
  always_comb begin
    if (proc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      arr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      arr_q       <= arr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // checks
  `ASSERT_CLKD(a_rise_done, clk_i, rst_ni, $rose(out_valid_q) |-> phase_q == PH_DONE)
  `ASSERT_CLKD(a_stall_held, clk_i, rst_ni, in_stall_o |-> in_valid_q && out_valid_q)
  `ASSERT_CLKD_MSG(a_err_clean, clk_i, rst_ni, out_valid_q && out_rsp_q.error_kind != ERR_OK |-> out_rsp_q.ret_type == TY_BYTE && !out_rsp_q.ret_array, "error result carries a type")
  `ASSERT_CLKD_MSG(a_not_method, clk_i, rst_ni, out_valid_q && out_rsp_q.error_kind == ERR_NOT_METHOD |-> out_rsp_q.arg_count == 8'd0, "bad first character with arguments")
  `ASSERT_CLKD(a_type_range, clk_i, rst_ni, out_valid_q |-> out_rsp_q.ret_type <= TY_REF && out_rsp_q.error_kind != 2'd3)

endmodule

### tb/sv/tb_method_descriptor_parser.sv
// testbench for the method descriptor parser: random and directed descriptors checked against a predictor
`timescale 1ns / 1ps

module tb_method_descriptor_parser;
  import mdp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1300;

  // descriptor letters
  localparam logic [7:0] CH_B = "B";
  localparam logic [7:0] CH_C = "C";
  localparam logic [7:0] CH_D = "D";
  localparam logic [7:0] CH_F = "F";
  localparam logic [7:0] CH_I = "I";
  localparam logic [7:0] CH_J = "J";
  localparam logic [7:0] CH_S = "S";
  localparam logic [7:0] CH_Z = "Z";
  localparam logic [7:0] CH_V = "V";

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_req_t   in_req_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_rsp_t  out_rsp_o;

  in_req_t   char_q[$];
  out_rsp_t  pending_rsp_q[$];

  logic [7:0] prim_chars [8] = '{CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z};
  logic [7:0] syntax_chars [14] = '{CH_OPEN, CH_CLOSE, CH_ARRAY, CH_CLASS, CH_SEMI,
                                    CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z, CH_V};

  // predictor state
  phase_e     ph = PH_IDLE;
  logic [7:0] nargs = '0;
  logic       ret_arr = 1'b0;

  int unsigned total_items = 0;
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned start_cnt = 0;
  int unsigned ok_cnt = 0;
  int unsigned bad_letter_cnt = 0;
  int unsigned not_method_cnt = 0;
  int unsigned saturated_cnt = 0;

  method_descriptor_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // idle percentage for each side, by stage of the run
  function automatic int unsigned gap_pct(bit rx);
    if (sent_cnt < total_items / 3) return rx ? 60 : 14;
    if (sent_cnt < 2 * total_items / 3) return rx ? 14 : 60;
    return 0;
  endfunction

  // primitive letter to type code
  function automatic logic [3:0] char_type(logic [7:0] c);
    case (c)
      CH_B:    return TY_BYTE;
      CH_C:    return TY_CHAR;
      CH_D:    return TY_DOUBLE;
      CH_F:    return TY_FLOAT;
      CH_I:    return TY_INT;
      CH_J:    return TY_LONG;
      CH_S:    return TY_SHORT;
      CH_Z:    return TY_BOOLEAN;
      CH_V:    return TY_VOID;
      default: return TY_NONE;
    endcase
  endfunction

  // queue a result and stop parsing until the next start
  task automatic post_result(logic [1:0] ek, logic [7:0] cnt, logic [3:0] ty, logic arr);
    out_rsp_t r;
    r.error_kind = ek;
    r.arg_count  = cnt;
    r.ret_type   = ty;
    r.ret_array  = arr;
    pending_rsp_q.push_back(r);
    ph = PH_DONE;
  endtask

  // advance the parser model by one accepted request
  task automatic parse_char(in_req_t r);
    logic [3:0] t;
    t = char_type(r.ch);
    if (r.start_req) begin
      nargs   = '0;
      ret_arr = 1'b0;
      if (r.ch != CH_OPEN) post_result(ERR_NOT_METHOD, 8'd0, TY_BYTE, 1'b0);
      else ph = PH_ARGS;
    end else begin
      case (ph)
        PH_ARGS, PH_ARGS_ARR: begin
          if (r.ch == CH_CLOSE && ph == PH_ARGS) ph = PH_RET;
          else if (r.ch == CH_ARRAY) ph = PH_ARGS_ARR;
          else if (r.ch == CH_CLASS) ph = PH_ARG_CLASS;
          else if (t == TY_NONE || t == TY_VOID) begin
            post_result(ERR_BAD_LETTER, nargs, TY_BYTE, 1'b0);
          end else begin
            if (nargs != CNT_MAX) nargs = nargs + 8'd1;
            ph = PH_ARGS;
          end
        end
        PH_ARG_CLASS: begin
          if (r.ch == CH_SEMI) begin
            if (nargs != CNT_MAX) nargs = nargs + 8'd1;
            ph = PH_ARGS;
          end
        end
        PH_RET: begin
          if (r.ch == CH_ARRAY) ret_arr = 1'b1;
          else if (r.ch == CH_CLASS) ph = PH_RET_CLASS;
          else if (t == TY_NONE || (t == TY_VOID && ret_arr)) begin
            post_result(ERR_BAD_LETTER, nargs, TY_BYTE, 1'b0);
          end else begin
            post_result(ERR_OK, nargs, t, ret_arr);
          end
        end
        PH_RET_CLASS: begin
          if (r.ch == CH_SEMI) post_result(ERR_OK, nargs, TY_REF, ret_arr);
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      err_cnt++;
    end
  endtask

  // stimulus helpers
  task automatic push_item(bit s, logic [7:0] c);
    in_req_t r;
    r.start_req = s;
    r.ch        = c;
    char_q.push_back(r);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(i == 0, s[i]);
  endtask

  function automatic logic [7:0] noise_char();
    if ($urandom_range(1)) return syntax_chars[$urandom_range(13)];
    return 8'($urandom_range(255));
  endfunction

  // one argument or return type with random prefixes and content
  task automatic push_field(bit is_ret);
    int unsigned dims;
    int unsigned kind;
    logic [7:0] c;
    dims = $urandom_range(1) ? 0 : $urandom_range(3, 1);
    kind = $urandom_range(99);
    repeat (dims) push_item(1'b0, CH_ARRAY);
    if (kind < 25) begin
      push_item(1'b0, CH_CLASS);
      repeat ($urandom_range(3)) begin
        c = 8'($urandom_range(255));
        if (c == CH_SEMI) c = CH_CLASS;
        push_item(1'b0, c);
      end
      push_item(1'b0, CH_SEMI);
    end else if (is_ret && dims == 0 && kind < 40) begin
      push_item(1'b0, CH_V);
    end else begin
      push_item(1'b0, prim_chars[$urandom_range(7)]);
    end
  endtask

  task automatic push_descriptor(int unsigned n);
    push_item(1'b1, CH_OPEN);
    repeat (n) push_field(1'b0);
    push_item(1'b0, CH_CLOSE);
    push_field(1'b1);
  endtask

  // driver: present the next pending request when the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (char_q.size() > 0 && $urandom_range(99) >= gap_pct(1'b0)) begin
        in_req_i   <= char_q.pop_front();
        in_valid_i <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < gap_pct(1'b1));
  end

  // monitor: check results, predict from requests, watch for a hang
  always @(posedge clk_i) begin : mon
    out_rsp_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp_o);
        err_cnt++;
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("error_kind", 32'(want.error_kind), 32'(out_rsp_o.error_kind));
        check_field("arg_count", 32'(want.arg_count), 32'(out_rsp_o.arg_count));
        check_field("ret_type", 32'(want.ret_type), 32'(out_rsp_o.ret_type));
        check_field("ret_array", 32'(want.ret_array), 32'(out_rsp_o.ret_array));
        case (want.error_kind)
          ERR_OK:         ok_cnt++;
          ERR_BAD_LETTER: bad_letter_cnt++;
          default:        not_method_cnt++;
        endcase
        if (want.arg_count == CNT_MAX) saturated_cnt++;
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      moved = 1'b1;
      if (in_req_i.start_req) start_cnt++;
      parse_char(in_req_i);
    end
    if (moved || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned sel;
    int unsigned mark;
    int unsigned cut;
    bit          overflow_done;
    overflow_done = 1'b0;

    // directed: ignored bytes, arrays and classes, empty class name, errors
    push_item(1'b0, 8'h00);
    push_text("([J[[LA;L;)[Z");
    push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'hFF);
    push_text("(V");
    push_text("(I");
    push_text("([)");
    push_text("()[V");
    push_text("()LX;");
    push_text("()V");

    // random: mostly well-formed descriptors, some broken ones and noise
    while (char_q.size() < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      mark = char_q.size();
      if (!overflow_done && char_q.size() > RANDOM_ITEMS / 2) begin
        // argument counter saturation
        push_descriptor(255 + $urandom_range(6));
        overflow_done = 1'b1;
      end else if (sel < 65) begin
        push_descriptor($urandom_range(6));
      end else if (sel < 78) begin
        // one character replaced by noise
        push_descriptor($urandom_range(4));
        cut = $urandom_range(char_q.size() - 1, mark + 1);
        char_q[cut].ch = noise_char();
      end else if (sel < 88) begin
        // abandoned part way, the next start takes over
        push_descriptor($urandom_range(4));
        repeat ($urandom_range(char_q.size() - mark - 1, 1)) void'(char_q.pop_back());
      end else if (sel < 95) begin
        push_item(1'b1, noise_char());
        repeat ($urandom_range(5)) push_item(1'b0, noise_char());
      end else begin
        // stray bytes, possibly with a start flag
        push_item(1'($urandom_range(1)), noise_char());
      end
    end
    total_items = char_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests and %0d descriptor starts", total_items, start_cnt);
    $display("results: %0d ok, %0d bad letter, %0d not a method, %0d with saturated count",
             ok_cnt, bad_letter_cnt, not_method_cnt, saturated_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/mdp_pkg.sv
hdl/method_descriptor_parser.sv
tb/sv/tb_method_descriptor_parser.sv
